/* rtl/stg_pkg.sv */
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types for the scrollbar thumb geometry block: datapath command
// and status groups, operand selects and result selects.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

   localparam int TRACK_W  = 8;
   localparam int DOC_W    = 16;
   localparam int PROD_W   = TRACK_W + DOC_W;
   localparam int DIV_BITS = 2;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_TP,
      MUL_VT,
      MUL_RQ,
      MUL_RR
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_LEN,
      DIV_FIT,
      DIV_QR,
      DIV_REM
   } div_sel_type;

   typedef enum logic [2:0] {
      RES_FULL,
      RES_FIT_END,
      RES_FIT_DIV,
      RES_POS_ZERO,
      RES_POS_END,
      RES_POS_DIV
   } res_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_len;
      logic        halve;
      logic        take_rel;
      logic        take_qr;
      logic        acc_load;
      logic        res_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic opcode;
      logic full;
      logic val_ge;
      logic lim_big;
      logic pos_zero;
      logic pos_end;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/stg_div.sv */
// ----------------------------------------------------------------------------
// stg_div
// Restoring unsigned divider, two quotient bits per cycle. Quotient and
// remainder hold after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [stg_pkg::PROD_W-1:0]    dividend,
   input  wire logic [stg_pkg::DOC_W-1:0]     divisor,
   output logic                               done,
   output logic [stg_pkg::PROD_W-1:0]         quotient,
   output logic [stg_pkg::DOC_W-1:0]          remainder
);

   localparam int QW    = stg_pkg::PROD_W;
   localparam int RW    = stg_pkg::DOC_W;
   localparam int STEPS = QW / stg_pkg::DIV_BITS;
   localparam int CW    = $clog2(STEPS);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] den_ff, den_in;

   always_comb begin
      logic [RW:0]   trial;
      logic [RW-1:0] r;
      logic [QW-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < stg_pkg::DIV_BITS; i++) begin
         trial = {r, q[QW-1]};
         q = {q[QW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
            q[0] = 1'b1;
         end
         r = trial[RW-1:0];
      end

      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = q;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/stg_datapath.sv */
// ----------------------------------------------------------------------------
// stg_datapath
// Operand registers, shared 8x16 multiplier, shared divider, clamping and
// limit halving, result registers. Driven by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_datapath #(
   parameter int MIN_THUMB = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire stg_pkg::dp_cmd_type        cmd,
   output stg_pkg::dp_status_type          status,
   input  wire logic                       req_opcode,
   input  wire logic [7:0]                 req_track,
   input  wire logic [15:0]                req_pos,
   input  wire logic [15:0]                req_total,
   input  wire logic [15:0]                req_page,
   input  wire logic [7:0]                 req_origin,
   input  wire logic [7:0]                 req_pointer,
   output logic [7:0]                      rsp_thumb_start,
   output logic [7:0]                      rsp_thumb_length,
   output logic [15:0]                     rsp_scroll_position
);

   localparam int PW = stg_pkg::PROD_W;

   logic        op_ff;
   logic [7:0]  track_ff, origin_ff, pointer_ff;
   logic [15:0] pos_ff, total_ff, page_ff;
   logic [PW-1:0] prod_ff, prod_in;
   logic [7:0]  len_ff, travel_ff, rel_ff, r_ff;
   logic [15:0] lim_ff, val_ff, dlim_ff, q_ff, acc_ff;
   logic [7:0]  start_ff, length_ff;
   logic [15:0] sp_ff;

   logic [7:0]    mul_a;
   logic [15:0]   mul_b;
   logic [PW-1:0] div_dividend;
   logic [15:0]   div_divisor;
   logic          div_done;
   logic [PW-1:0] div_quo;
   logic [15:0]   div_rem;

   logic [15:0] lim_now, pos_c;
   logic [7:0]  len_q, len_c, half;
   logic [8:0]  edge_pt;
   logic [8:0]  rel_wide;
   logic [7:0]  rel_now;

   stg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      mul_a = 8'd0;
      mul_b = 16'd0;
      case (cmd.mul_sel)
         stg_pkg::MUL_TP: begin
            mul_a = track_ff;
            mul_b = page_ff;
         end
         stg_pkg::MUL_VT: begin
            mul_a = val_ff[7:0];
            mul_b = {8'd0, travel_ff};
         end
         stg_pkg::MUL_RQ: begin
            mul_a = rel_ff;
            mul_b = q_ff;
         end
         stg_pkg::MUL_RR: begin
            mul_a = rel_ff;
            mul_b = {8'd0, r_ff};
         end
         default: begin
            mul_a = 8'd0;
            mul_b = 16'd0;
         end
      endcase
      prod_in = (cmd.mul_sel == stg_pkg::MUL_NONE) ? prod_ff : (PW'(mul_a) * PW'(mul_b));
   end

   always_comb begin
      div_dividend = prod_ff;
      div_divisor  = total_ff;
      case (cmd.div_sel)
         stg_pkg::DIV_LEN: div_divisor = total_ff;
         stg_pkg::DIV_FIT: div_divisor = dlim_ff;
         stg_pkg::DIV_QR: begin
            div_dividend = PW'(lim_ff);
            div_divisor  = {8'd0, travel_ff};
         end
         stg_pkg::DIV_REM: div_divisor = {8'd0, travel_ff};
         default: div_divisor = total_ff;
      endcase
   end

   always_comb begin
      lim_now  = total_ff - page_ff;
      pos_c    = (pos_ff > lim_now) ? lim_now : pos_ff;
      len_q    = div_quo[7:0];
      len_c    = (len_q < 8'(MIN_THUMB)) ? 8'(MIN_THUMB) : len_q;
      if (len_c > track_ff) begin
         len_c = track_ff;
      end
      half     = len_ff >> 1;
      edge_pt  = {1'b0, origin_ff} + {1'b0, half};
      rel_wide = {1'b0, pointer_ff} - edge_pt;
      rel_now  = rel_wide[7:0];
   end

   assign status.opcode   = op_ff;
   assign status.full     = (page_ff >= total_ff);
   assign status.val_ge   = (val_ff >= dlim_ff);
   assign status.lim_big  = |dlim_ff[15:8];
   assign status.pos_zero = (travel_ff == 8'd0) || ({1'b0, pointer_ff} <= edge_pt);
   assign status.pos_end  = (rel_now >= travel_ff);
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         track_ff   <= req_track;
         pos_ff     <= req_pos;
         total_ff   <= req_total;
         page_ff    <= req_page;
         origin_ff  <= req_origin;
         pointer_ff <= req_pointer;
      end
      prod_ff <= prod_in;
      if (cmd.take_len) begin
         len_ff    <= len_c;
         travel_ff <= track_ff - len_c;
         lim_ff    <= lim_now;
         dlim_ff   <= lim_now;
         val_ff    <= pos_c;
      end
      if (cmd.halve) begin
         val_ff  <= val_ff >> 1;
         dlim_ff <= (dlim_ff >> 1) + {15'd0, dlim_ff[0]};
      end
      if (cmd.take_rel) begin
         rel_ff <= rel_now;
      end
      if (cmd.take_qr) begin
         q_ff <= div_quo[15:0];
         r_ff <= div_rem[7:0];
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff[15:0];
      end
      if (cmd.res_load) begin
         case (cmd.res_sel)
            stg_pkg::RES_FULL: begin
               start_ff  <= 8'd0;
               length_ff <= track_ff;
               sp_ff     <= 16'd0;
            end
            stg_pkg::RES_FIT_END: begin
               start_ff  <= travel_ff;
               length_ff <= len_ff;
               sp_ff     <= 16'd0;
            end
            stg_pkg::RES_FIT_DIV: begin
               start_ff  <= div_quo[7:0];
               length_ff <= len_ff;
               sp_ff     <= 16'd0;
            end
            stg_pkg::RES_POS_ZERO: begin
               start_ff  <= 8'd0;
               length_ff <= len_ff;
               sp_ff     <= 16'd0;
            end
            stg_pkg::RES_POS_END: begin
               start_ff  <= 8'd0;
               length_ff <= len_ff;
               sp_ff     <= lim_ff;
            end
            stg_pkg::RES_POS_DIV: begin
               start_ff  <= 8'd0;
               length_ff <= len_ff;
               sp_ff     <= acc_ff + div_quo[15:0];
            end
            default: begin
               start_ff  <= 8'd0;
               length_ff <= 8'd0;
               sp_ff     <= 16'd0;
            end
         endcase
      end
   end

   assign rsp_thumb_start     = start_ff;
   assign rsp_thumb_length    = length_ff;
   assign rsp_scroll_position = sp_ff;

endmodule

`default_nettype wire

/* rtl/stg_ctrl.sv */
// ----------------------------------------------------------------------------
// stg_ctrl
// Sequencer for one transaction: a full-page check, else thumb length, then
// start fitting or pointer-to-position, then a one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   output stg_pkg::dp_cmd_type        cmd,
   input  wire stg_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_LEN_GO,
      S_LEN_WAIT,
      S_FIT,
      S_HALVE,
      S_FIT_GO,
      S_FIT_WAIT,
      S_POS,
      S_QR_WAIT,
      S_MUL_Q,
      S_MUL_R,
      S_REM_GO,
      S_REM_WAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.mul_sel = stg_pkg::MUL_TP;
            if (status.full) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stg_pkg::RES_FULL;
               state_in     = S_OUT;
            end else begin
               state_in = S_LEN_GO;
            end
         end
         S_LEN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = stg_pkg::DIV_LEN;
            state_in      = S_LEN_WAIT;
         end
         S_LEN_WAIT: begin
            cmd.div_sel = stg_pkg::DIV_LEN;
            if (status.div_done) begin
               cmd.take_len = 1'b1;
               state_in     = status.opcode ? S_POS : S_FIT;
            end
         end
         S_FIT: begin
            if (status.val_ge) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stg_pkg::RES_FIT_END;
               state_in     = S_OUT;
            end else begin
               state_in = S_HALVE;
            end
         end
         S_HALVE: begin
            if (status.lim_big) begin
               cmd.halve = 1'b1;
            end else begin
               cmd.mul_sel = stg_pkg::MUL_VT;
               state_in    = S_FIT_GO;
            end
         end
         S_FIT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = stg_pkg::DIV_FIT;
            state_in      = S_FIT_WAIT;
         end
         S_FIT_WAIT: begin
            cmd.div_sel = stg_pkg::DIV_FIT;
            if (status.div_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stg_pkg::RES_FIT_DIV;
               state_in     = S_OUT;
            end
         end
         S_POS: begin
            if (status.pos_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stg_pkg::RES_POS_ZERO;
               state_in     = S_OUT;
            end else if (status.pos_end) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stg_pkg::RES_POS_END;
               state_in     = S_OUT;
            end else begin
               cmd.take_rel  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = stg_pkg::DIV_QR;
               state_in      = S_QR_WAIT;
            end
         end
         S_QR_WAIT: begin
            cmd.div_sel = stg_pkg::DIV_QR;
            if (status.div_done) begin
               cmd.take_qr = 1'b1;
               state_in    = S_MUL_Q;
            end
         end
         S_MUL_Q: begin
            cmd.mul_sel = stg_pkg::MUL_RQ;
            state_in    = S_MUL_R;
         end
         S_MUL_R: begin
            cmd.acc_load = 1'b1;
            cmd.mul_sel  = stg_pkg::MUL_RR;
            state_in     = S_REM_GO;
         end
         S_REM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = stg_pkg::DIV_REM;
            state_in      = S_REM_WAIT;
         end
         S_REM_WAIT: begin
            cmd.div_sel = stg_pkg::DIV_REM;
            if (status.div_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stg_pkg::RES_POS_DIV;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

`default_nettype wire

/* rtl/scrollbar_thumb_geometry.sv */
// ----------------------------------------------------------------------------
// scrollbar_thumb_geometry
// Thumb start/length from a scroll position, or scroll position from a
// pointer coordinate, over a 16-bit document and an 8-bit track.
// A page that covers the document is answered without a divider pass; thumb
// geometry takes the thumb-length pass, up to 9 limit-halving steps and a
// fitting pass, pointer to position three passes; early exits skip the rest.
// One transaction at a time: busy from acceptance to the strobe, and the
// receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scrollbar_thumb_geometry #(
   parameter int MIN_THUMB = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_track,
   input  wire logic [15:0] req_pos,
   input  wire logic [15:0] req_total,
   input  wire logic [15:0] req_page,
   input  wire logic [7:0]  req_origin,
   input  wire logic [7:0]  req_pointer,
   output logic             rsp_valid,
   output logic [7:0]       rsp_thumb_start,
   output logic [7:0]       rsp_thumb_length,
   output logic [15:0]      rsp_scroll_position
);

   stg_pkg::dp_cmd_type    cmd;
   stg_pkg::dp_status_type status;

   stg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   stg_datapath #(
      .MIN_THUMB (MIN_THUMB)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_track           (req_track),
      .req_pos             (req_pos),
      .req_total           (req_total),
      .req_page            (req_page),
      .req_origin          (req_origin),
      .req_pointer         (req_pointer),
      .rsp_thumb_start     (rsp_thumb_start),
      .rsp_thumb_length    (rsp_thumb_length),
      .rsp_scroll_position (rsp_scroll_position)
   );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for scrollbar_thumb_geometry. A directed table covers the edge
// cases: empty or fully visible documents, short tracks, positions past the
// end, no free travel and pointers at both ends. Random transactions follow.
// All are sent in bursts with random gaps. Every strobed result is compared
// field by field against an in-bench predictor, or against a typed value
// where the table gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int MIN_THUMB    = 4;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_MAX   = 10;

   typedef enum logic {
      OP_GEOMETRY = 1'b0,
      OP_POSITION = 1'b1
   } scroll_op_type;

   typedef struct {
      scroll_op_type                opcode;
      logic [stg_pkg::TRACK_W-1:0]  track;
      logic [stg_pkg::DOC_W-1:0]    pos;
      logic [stg_pkg::DOC_W-1:0]    total;
      logic [stg_pkg::DOC_W-1:0]    page;
      logic [7:0]                   origin;
      logic [7:0]                   pointer;
   } scroll_req_type;

   typedef struct {
      logic [7:0]  thumb_start;
      logic [7:0]  thumb_length;
      logic [15:0] scroll_position;
   } thumb_geom_type;

   typedef struct {
      scroll_req_type req;
      bit             typed;
      thumb_geom_type geom;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [7:0]  req_track;
   logic [15:0] req_pos;
   logic [15:0] req_total;
   logic [15:0] req_page;
   logic [7:0]  req_origin;
   logic [7:0]  req_pointer;
   logic        rsp_valid;
   logic [7:0]  rsp_thumb_start;
   logic [7:0]  rsp_thumb_length;
   logic [15:0] rsp_scroll_position;

   thumb_geom_type expected_geometry_q[$];
   table_row_type  stimulus_table[$];
   int             mismatches;
   int             results_checked;
   int             geometry_sent;
   int             position_sent;
   int             cycle_count;
   int             burst_left;

   scrollbar_thumb_geometry #(
      .MIN_THUMB(MIN_THUMB)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_track          (req_track),
      .req_pos            (req_pos),
      .req_total          (req_total),
      .req_page           (req_page),
      .req_origin         (req_origin),
      .req_pointer        (req_pointer),
      .rsp_valid          (rsp_valid),
      .rsp_thumb_start    (rsp_thumb_start),
      .rsp_thumb_length   (rsp_thumb_length),
      .rsp_scroll_position(rsp_scroll_position)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int unsigned scale_onto_travel(int unsigned value, int unsigned limit,
                                                     int unsigned span);
      if (limit == 0 || value >= limit) return span;
      while (limit > 255) begin
         value = value >> 1;
         limit = (limit >> 1) + (limit & 1);
      end
      return (value * span) / limit;
   endfunction

   function automatic thumb_geom_type predict_geometry(scroll_req_type r);
      int unsigned trk, tot, pg, len, lim, p, st, travel, half, org, ptr, rel, q, rm, sp;
      thumb_geom_type g;
      trk = r.track;
      tot = r.total;
      pg  = r.page;
      org = r.origin;
      ptr = r.pointer;
      g.thumb_start     = '0;
      g.thumb_length    = r.track;
      g.scroll_position = '0;
      if (tot == 0 || pg >= tot) return g;
      len = (trk * pg) / tot;
      if (len < MIN_THUMB) len = MIN_THUMB;
      if (len > trk) len = trk;
      lim = tot - pg;
      g.thumb_length = len[7:0];
      if (r.opcode == OP_GEOMETRY) begin
         p  = (r.pos > lim) ? lim : r.pos;
         st = scale_onto_travel(p, lim, trk - len);
         g.thumb_start = st[7:0];
      end else begin
         travel = trk - len;
         half   = len >> 1;
         sp     = 0;
         if (travel != 0 && ptr > org + half) begin
            rel = ptr - org - half;
            if (rel >= travel) begin
               sp = lim;
            end else begin
               q  = lim / travel;
               rm = lim % travel;
               sp = rel * q + (rel * rm) / travel;
            end
         end
         g.scroll_position = sp[15:0];
      end
      return g;
   endfunction

   function automatic scroll_req_type random_request();
      scroll_req_type r;
      int unsigned trk, tot, pg, ps, org, ptr, shape;
      r.opcode = scroll_op_type'($urandom_range(0, 1));
      shape    = $urandom_range(0, 9);
      case ($urandom_range(0, 7))
         0: begin
            trk = $urandom_range(0, 8);
         end
         1: begin
            trk = 255;
         end
         default: begin
            trk = $urandom_range(0, 255);
         end
      endcase
      // mostly a partly visible document, so the dividers are exercised
      if (shape == 0) begin
         tot = $urandom_range(0, 65535);
         pg  = $urandom_range(0, 65535);
      end else begin
         tot = (shape == 1) ? $urandom_range(1, 40) : $urandom_range(1, 65535);
         case ($urandom_range(0, 3))
            0: begin
               pg = $urandom_range(0, tot / 64);
            end
            1: begin
               pg = tot - 1 - $urandom_range(0, (tot - 1 < 300) ? tot - 1 : 300);
            end
            default: begin
               pg = $urandom_range(0, tot - 1);
            end
         endcase
      end
      case ($urandom_range(0, 5))
         0: begin
            ps = 0;
         end
         1: begin
            ps = 65535;
         end
         2: begin
            ps = $urandom_range(0, 65535);
         end
         default: begin
            ps = $urandom_range(0, tot);
         end
      endcase
      org = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 255 - trk);
      if ($urandom_range(0, 3) == 0) begin
         ptr = $urandom_range(0, 255);
      end else begin
         ptr = org + $urandom_range(0, trk + 8);
         if (ptr > 255) ptr = 255;
      end
      r.track   = trk[7:0];
      r.total   = tot[15:0];
      r.page    = pg[15:0];
      r.pos     = ps[15:0];
      r.origin  = org[7:0];
      r.pointer = ptr[7:0];
      return r;
   endfunction

   task automatic add_row(input scroll_op_type op, input int trk, input int ps, input int tot,
                          input int pg, input int org, input int ptr, input bit typed,
                          input int st, input int ln, input int sp);
      table_row_type row;
      row.req.opcode  = op;
      row.req.track   = trk[7:0];
      row.req.pos     = ps[15:0];
      row.req.total   = tot[15:0];
      row.req.page    = pg[15:0];
      row.req.origin  = org[7:0];
      row.req.pointer = ptr[7:0];
      row.typed                = typed;
      row.geom.thumb_start     = st[7:0];
      row.geom.thumb_length    = ln[7:0];
      row.geom.scroll_position = sp[15:0];
      stimulus_table.push_back(row);
   endtask

   // presents one transaction and returns at the edge that accepts it
   task automatic send_request(input scroll_req_type r, input bit typed,
                               input thumb_geom_type g);
      start       <= 1'b1;
      req_opcode  <= r.opcode;
      req_track   <= r.track;
      req_pos     <= r.pos;
      req_total   <= r.total;
      req_page    <= r.page;
      req_origin  <= r.origin;
      req_pointer <= r.pointer;
      do @(posedge clock); while (busy);
      expected_geometry_q.push_back(typed ? g : predict_geometry(r));
      if (r.opcode == OP_GEOMETRY) geometry_sent++;
      else position_sent++;
   endtask

   task automatic sender_idle();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_geometry_q.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input thumb_geom_type want);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("[%0d] %s: exp start %0d len %0d pos %0d, got start %0d len %0d pos %0d",
                  cycle_count, what, want.thumb_start, want.thumb_length,
                  want.scroll_position, rsp_thumb_start, rsp_thumb_length,
                  rsp_scroll_position);
   endtask

   always @(posedge clock) begin
      thumb_geom_type want;
      if (!reset && rsp_valid) begin
         if (expected_geometry_q.size() == 0) begin
            want = '{default: '0};
            report_mismatch("unexpected result", want);
         end else begin
            want = expected_geometry_q.pop_front();
            results_checked++;
            if (rsp_thumb_start !== want.thumb_start ||
                rsp_thumb_length !== want.thumb_length ||
                rsp_scroll_position !== want.scroll_position)
               report_mismatch("wrong result", want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
                  expected_geometry_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      thumb_geom_type none;
      reset       = 1'b1;
      start       = 1'b0;
      req_opcode  = 1'b0;
      req_track   = '0;
      req_pos     = '0;
      req_total   = '0;
      req_page    = '0;
      req_origin  = '0;
      req_pointer = '0;
      none        = '{default: '0};
      burst_left  = 0;

      // empty and fully visible documents
      add_row(OP_GEOMETRY, 200, 0, 0, 0, 0, 0, 1, 0, 200, 0);
      add_row(OP_GEOMETRY, 255, 40, 100, 100, 0, 0, 1, 0, 255, 0);
      add_row(OP_POSITION, 77, 0, 0, 0, 10, 90, 1, 0, 77, 0);
      add_row(OP_GEOMETRY, 255, 65535, 65535, 65535, 255, 255, 1, 0, 255, 0);
      add_row(OP_POSITION, 255, 65535, 65535, 65535, 255, 255, 1, 0, 255, 0);
      add_row(OP_POSITION, 30, 0, 5, 65535, 0, 200, 1, 0, 30, 0);
      // tracks shorter than the minimum thumb
      add_row(OP_GEOMETRY, 0, 5, 1000, 10, 0, 0, 1, 0, 0, 0);
      add_row(OP_GEOMETRY, 3, 990, 1000, 10, 0, 0, 1, 0, 3, 0);
      add_row(OP_POSITION, 0, 0, 1000, 10, 0, 100, 1, 0, 0, 0);
      // position clamping and track ends
      add_row(OP_GEOMETRY, 100, 65535, 1000, 100, 0, 0, 1, 90, 10, 0);
      add_row(OP_GEOMETRY, 100, 0, 1000, 100, 0, 0, 1, 0, 10, 0);
      add_row(OP_GEOMETRY, 255, 0, 65535, 0, 0, 0, 1, 0, 4, 0);
      add_row(OP_GEOMETRY, 255, 65535, 65535, 0, 0, 0, 1, 251, 4, 0);
      add_row(OP_GEOMETRY, 255, 0, 1, 0, 0, 0, 1, 0, 4, 0);
      add_row(OP_GEOMETRY, 255, 3, 65535, 65534, 0, 0, 0, 0, 0, 0);
      add_row(OP_GEOMETRY, 200, 12345, 50000, 1000, 0, 0, 0, 0, 0, 0);
      // pointer to position
      add_row(OP_POSITION, 100, 0, 1000, 100, 50, 55, 1, 0, 10, 0);
      add_row(OP_POSITION, 100, 0, 1000, 100, 50, 56, 0, 0, 0, 0);
      add_row(OP_POSITION, 100, 0, 1000, 100, 0, 255, 1, 0, 10, 900);
      add_row(OP_POSITION, 4, 0, 1000, 10, 0, 200, 1, 0, 4, 0);
      add_row(OP_POSITION, 100, 0, 1000, 100, 10, 60, 0, 0, 0, 0);
      add_row(OP_POSITION, 255, 0, 65535, 1, 0, 128, 0, 0, 0, 0);
      add_row(OP_POSITION, 255, 0, 65535, 65534, 0, 200, 0, 0, 0, 0);
      add_row(OP_POSITION, 40, 0, 777, 33, 200, 10, 1, 0, 4, 0);
      add_row(OP_POSITION, 255, 0, 65535, 1, 255, 255, 1, 0, 4, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stimulus_table[i]) begin
         sender_idle();
         send_request(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].geom);
      end
      hold_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 200 == 100) hold_until_drained();
         else sender_idle();
         send_request(random_request(), 1'b0, none);
      end
      start <= 1'b0;

      while (expected_geometry_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d directed and %0d random transactions (%0d geometry, %0d position)",
               stimulus_table.size(), RANDOM_ITEMS, geometry_sent, position_sent);
      $display("Checked %0d results in %0d cycles, error count %0d", results_checked,
               cycle_count, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* scrollbar_thumb_geometry.f */
rtl/stg_pkg.sv
rtl/stg_div.sv
rtl/stg_datapath.sv
rtl/stg_ctrl.sv
rtl/scrollbar_thumb_geometry.sv
test/tb_top.sv
